[rtl/seeprom_pkg.sv]
// Shared types and constants for the two-wire serial EEPROM slave.
// No dependencies; imported by serial_eeprom_two_wire_slave_top.
package seeprom_pkg;

    typedef enum logic [2:0] {
        PH_SELECT  = 3'd0,
        PH_ADDRESS = 3'd1,
        PH_READ    = 3'd2,
        PH_WRITE   = 3'd3,
        PH_ACK     = 3'd4,
        PH_NOACK   = 3'd5,
        PH_ACKWAIT = 3'd6,
        PH_IDLE    = 3'd7
    } phase_t;

    localparam logic [7:0] SELECT_MASK  = 8'ha0;
    localparam logic [7:0] LOW7_MASK    = 8'h7f;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic       MODE_SMALL   = 1'b0;
    localparam logic       MODE_FULL    = 1'b1;

    // Bit position of the next serial bit: MSB first in the large variant.
    function automatic logic [2:0] bit_pos(input logic mode, input logic [3:0] taken);
        logic [2:0] pos;
        pos = (mode == MODE_SMALL) ? taken[2:0] : (3'd7 - taken[2:0]);
        return pos;
    endfunction

endpackage

[rtl/serial_eeprom_two_wire_slave_top.sv]
// Two-wire serial EEPROM slave: line sampling, bus protocol and byte store.
// Depends on seeprom_pkg.
//
// Usage:
//   s_ channel carries one line sample per transaction (scl, sda). Every
//   accepted sample produces exactly one m_ transaction holding sda_out, the
//   level the device drives on the data line after that sample.
//   cfg channel writes size_mode (0 = 128-byte LSB-first, 1 = 256-byte
//   MSB-first with select check); write it only while the stream is idle.
// Throughput and timing:
//   One sample per cycle sustained while m_tready stays high; the result is registered and
//   appears in the cycle after the sample is accepted. A store read is issued at the
//   sample that needs it and its registered data is picked up by the following sample.
// Reset:
//   aresetn low clears the protocol state, selects the 256-byte mode and
//   marks every store byte invalid, so unwritten bytes read as zero at once.
// Stall:
//   The result register drains when m_tready is high; while it is full and
//   m_tready is low, s_tready drops and the sample stream holds.
module serial_eeprom_two_wire_slave_top #(
    parameter int STORE_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] scl, [1] sda, [7:2] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] sda_out, [7:1] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // size_mode
);
    import seeprom_pkg::*;

    localparam int         IDX_W  = $clog2(STORE_BYTES);
    localparam logic [8:0] SIZE_W = 9'(STORE_BYTES);

    logic       size_mode_reg;
    logic       last_clock_reg, last_data_reg;
    phase_t     phase_reg, phase_next;
    phase_t     after_ack_reg, after_ack_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] shift_reg, shift_next;
    logic       read_flag_reg, read_flag_next;
    logic       drive_reg, drive_next;
    logic       load_pend_reg, load_req;
    logic       store_we;

    logic [7:0]             mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] vld_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       wr_idx, rd_idx;

    logic       m_tvalid_reg;
    logic       sda_out_reg;
    logic       s_accept;
    logic       scl, sda;
    logic [7:0] shift_eff;
    logic [2:0] pos;
    logic [7:0] addr_inc;
    logic [8:0] wr_a9, rd_a9;

    assign scl       = s_tdata[0];
    assign sda       = s_tdata[1];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, sda_out_reg};

    // A pending load resolves to the registered store data; invalid bytes read zero.
    assign shift_eff = load_pend_reg ? (rd_vld_reg ? rd_data_reg : 8'd0) : shift_reg;
    assign pos       = bit_pos(size_mode_reg, bits_reg);
    assign addr_inc  = (size_mode_reg == MODE_SMALL) ? {1'b0, addr_reg[6:0] + 7'd1}
                                                     : addr_reg + 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        after_ack_next = after_ack_reg;
        bits_next      = bits_reg;
        addr_next      = addr_reg;
        shift_next     = shift_eff;
        read_flag_next = read_flag_reg;
        drive_next     = drive_reg;
        load_req       = 1'b0;
        store_we       = 1'b0;

        if (last_clock_reg && !sda && last_data_reg) begin
            // start condition
            phase_next = PH_SELECT;
            bits_next  = 4'd0;
            drive_next = 1'b1;
            if (size_mode_reg == MODE_SMALL) begin
                addr_next = 8'd0;
            end
        end else if (last_clock_reg && sda && !last_data_reg) begin
            // stop condition
            phase_next = PH_IDLE;
            drive_next = 1'b1;
        end else if (scl && !last_clock_reg) begin
            case (phase_reg)
                PH_SELECT, PH_WRITE: begin
                    if (bits_reg < BITS_PER_BYTE) begin
                        shift_next[pos] = sda;
                        bits_next       = bits_reg + 4'd1;
                    end
                end
                PH_ADDRESS: begin
                    if (bits_reg < BITS_PER_BYTE) begin
                        addr_next[pos] = sda;
                        bits_next      = bits_reg + 4'd1;
                    end
                end
                PH_ACK:   drive_next = 1'b0;
                PH_NOACK: drive_next = 1'b1;
                PH_ACKWAIT: begin
                    if (size_mode_reg != MODE_SMALL && !sda) begin
                        after_ack_next = PH_READ;
                        load_req       = 1'b1;
                    end else if (size_mode_reg != MODE_SMALL || !sda) begin
                        after_ack_next = PH_IDLE;
                    end
                end
                PH_READ: begin
                    if (bits_reg < BITS_PER_BYTE) begin
                        drive_next = shift_eff[pos];
                        bits_next  = bits_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end else if (!scl && last_clock_reg) begin
            case (phase_reg)
                PH_SELECT: begin
                    if (bits_reg == BITS_PER_BYTE) begin
                        drive_next = 1'b1;
                        if (size_mode_reg != MODE_SMALL &&
                            (shift_eff & SELECT_MASK) != SELECT_MASK) begin
                            phase_next     = PH_NOACK;
                            after_ack_next = PH_IDLE;
                        end else begin
                            phase_next = PH_ACK;
                            if (size_mode_reg == MODE_SMALL) begin
                                read_flag_next = shift_eff[7];
                                shift_next     = shift_eff & LOW7_MASK;
                                addr_next      = shift_eff & LOW7_MASK;
                            end else begin
                                read_flag_next = shift_eff[0];
                            end
                            if (read_flag_next) begin
                                after_ack_next = PH_READ;
                                load_req       = 1'b1;
                            end else begin
                                after_ack_next = (size_mode_reg == MODE_SMALL) ? PH_WRITE
                                                                               : PH_ADDRESS;
                            end
                        end
                    end
                end
                PH_ACK: begin
                    phase_next = after_ack_reg;
                    bits_next  = 4'd0;
                    drive_next = 1'b1;
                end
                PH_NOACK: begin
                    phase_next = PH_IDLE;
                    bits_next  = 4'd0;
                    drive_next = 1'b1;
                end
                PH_ACKWAIT: begin
                    if (size_mode_reg != MODE_SMALL) begin
                        phase_next = after_ack_reg;
                        bits_next  = 4'd0;
                        drive_next = 1'b1;
                    end
                end
                PH_READ: begin
                    if (bits_reg == BITS_PER_BYTE) begin
                        phase_next = PH_ACKWAIT;
                        drive_next = 1'b1;
                        addr_next  = addr_inc;
                    end
                end
                PH_WRITE: begin
                    if (bits_reg == BITS_PER_BYTE) begin
                        phase_next = PH_ACK;
                        if (size_mode_reg != MODE_SMALL) begin
                            bits_next      = 4'd0;
                            after_ack_next = PH_WRITE;
                        end else begin
                            after_ack_next = PH_IDLE;
                        end
                        store_we  = 1'b1;
                        addr_next = addr_inc;
                    end
                end
                PH_ADDRESS: begin
                    if (bits_reg == BITS_PER_BYTE) begin
                        bits_next      = 4'd0;
                        phase_next     = PH_ACK;
                        after_ack_next = read_flag_reg ? PH_IDLE : PH_WRITE;
                        drive_next     = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Fold the byte address onto the store; address is below twice the store size.
    always_comb begin
        wr_a9 = {1'b0, addr_reg};
        if (wr_a9 >= SIZE_W) begin
            wr_a9 = wr_a9 - SIZE_W;
        end
        rd_a9 = {1'b0, addr_next};
        if (rd_a9 >= SIZE_W) begin
            rd_a9 = rd_a9 - SIZE_W;
        end
    end
    assign wr_idx = wr_a9[IDX_W-1:0];
    assign rd_idx = rd_a9[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (s_accept && store_we) begin
            mem[wr_idx] <= shift_eff;
        end
        if (s_accept && load_req) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else if (s_accept) begin
            if (store_we) begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (load_req) begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_mode_reg <= MODE_FULL;
        end else if (cfg_valid && cfg_ready) begin
            size_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_clock_reg <= 1'b0;
            last_data_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            after_ack_reg  <= PH_SELECT;
            bits_reg       <= 4'd0;
            addr_reg       <= 8'd0;
            shift_reg      <= 8'd0;
            read_flag_reg  <= 1'b0;
            drive_reg      <= 1'b1;
            load_pend_reg  <= 1'b0;
        end else if (s_accept) begin
            last_clock_reg <= scl;
            last_data_reg  <= sda;
            phase_reg      <= phase_next;
            after_ack_reg  <= after_ack_next;
            bits_reg       <= bits_next;
            addr_reg       <= addr_next;
            shift_reg      <= shift_next;
            read_flag_reg  <= read_flag_next;
            drive_reg      <= drive_next;
            load_pend_reg  <= load_req;
        end
    end

    // Result register: refill on accept, drain on downstream take.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sda_out_reg <= drive_next;
        end
    end

    a_pend_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(load_pend_reg) |-> $past(s_accept))
        else $error("store load pending without an accepted sample");

    a_bits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    a_drive_low_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !drive_reg |-> (phase_reg == PH_ACK || phase_reg == PH_READ))
        else $error("data line driven low outside acknowledge or read");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tvalid_reg && sda_out_reg == drive_reg))
        else $error("result register does not match protocol state");

endmodule
